### rtl/core/ccss_pkg.sv
// ----------------------------------------------------------------------------
// ccss_pkg: shared types and constants for the Cesaro segment subdivider
// Beat structs, angle width, CORDIC sizing, arctangent table and the
// control word passed from the sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ccss_pkg;

  localparam int ANGLE_BITS   = 16;   // binary angle units per turn = 2^ANGLE_BITS
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(CORDIC_N);
  localparam int TRIG_FRAC    = 30;   // cos/sin are Q30

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [15:0] point_heading;
    logic               starts_curve;
  } ccss_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic        [15:0] out_heading;
    logic               last_of_run;
  } ccss_out_t;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_BASE,   // (p + 2^29) >>> 30
    MAC_LOAD,   // acc = p
    MAC_SUB,    // (acc - 2p + 2^30) >>> 31
    MAC_ADD     // (acc + 2p + 2^30) >>> 31
  } mac_mode_e;

  typedef struct packed {
    logic      mul_en;
    logic      acc_en;
    mac_mode_e mode;
  } mac_ctl_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2E;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/cesaro_curve_segment_subdivider.sv
// ----------------------------------------------------------------------------
// cesaro_curve_segment_subdivider: one Cesaro curve level to the next
// Replaces each segment by the notch base, apex and second base points.
// ----------------------------------------------------------------------------
// A curve-start vertex is accepted and then gives its single pass-through
// beat. Every other vertex goes through the CORDIC (16 shift-add steps, one
// load and one fold correction), a hand-off, the single 32x32 multiplier
// (eight products, one per cycle unless the output stalls, each registered
// and then folded and rounded) and the final beat. Output back-pressure
// adds cycles only at the three point beats and the final beat. The input
// is ready only while the block is idle; the output register lets the last
// beat wait for the sink while the next vertex is already accepted.
// Configuration may be written at any time the block is idle and applies to
// the next vertex.
module cesaro_curve_segment_subdivider import ccss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_wdata_i,
  // vertex input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ccss_in_t    in_data_i,
  // vertex output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ccss_out_t   out_data_o
);

  // register indexes
  localparam logic [1:0] REG_SIDE_LENGTH = 2'd0;
  localparam logic [1:0] REG_CUT_LENGTH  = 2'd1;
  localparam logic [1:0] REG_PEAK_HEIGHT = 2'd2;
  localparam logic [1:0] REG_TURN_ANGLE  = 2'd3;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CORDIC = 2'd1;
  localparam logic [1:0] ST_MUL    = 2'd2;
  localparam logic [1:0] ST_LAST   = 2'd3;

  // product schedule: operand pair per op
  localparam logic [2:0] OP_R_C = 3'd0;  // base 1 x
  localparam logic [2:0] OP_R_S = 3'd1;  // base 1 y, beat
  localparam logic [2:0] OP_L_C = 3'd2;  // apex x, load
  localparam logic [2:0] OP_H_S = 3'd3;  // apex x, minus 2hs
  localparam logic [2:0] OP_L_S = 3'd4;  // apex y, load
  localparam logic [2:0] OP_H_C = 3'd5;  // apex y, plus 2hc, beat
  localparam logic [2:0] OP_D_C = 3'd6;  // base 2 x
  localparam logic [2:0] OP_D_S = 3'd7;  // base 2 y, beat

  logic [1:0]         state_q;
  logic [3:0]         iss_q;     // next op to issue, 8 = all issued
  logic               pv_q;      // product in flight
  logic [2:0]         pop_q;     // op of product in flight

  logic [30:0]        side_q, cut_q, peak_q;
  logic [15:0]        turn_q;

  logic [31:0]        prev_x_q, prev_y_q;
  angle_t             prev_hd_q;
  logic [31:0]        cur_x_q, cur_y_q;
  angle_t             cur_hd_q;
  logic [31:0]        ox_q;

  logic               out_valid_q;
  ccss_out_t          out_data_q;

  logic               in_acc, cordic_start, cordic_done;
  logic signed [31:0] cos_w, sin_w;
  logic               out_free, comb_y, comb_x, stall, mul_run, issue;
  logic               emit_mid, emit_last;
  mac_ctl_t           mac_ctl;
  logic signed [31:0] op_a, op_b;
  logic signed [31:0] len_l, len_r, len_h, len_d;
  logic [31:0]        mac_base, coord;
  angle_t             alfa, emit_hd;

  // ---------------------------------------------------------------------------
  // control decode
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    in_acc       = in_valid_i && in_ready_o;
    cordic_start = in_acc && !in_data_i.starts_curve;
    out_free     = !out_valid_q || out_ready_i;

    // y results complete a point and need the output register
    comb_y  = pv_q && (pop_q == OP_R_S || pop_q == OP_H_C || pop_q == OP_D_S);
    comb_x  = pv_q && (pop_q == OP_R_C || pop_q == OP_H_S || pop_q == OP_D_C);
    stall   = comb_y && !out_free;
    mul_run = (state_q == ST_MUL) && !stall;
    issue   = mul_run && !iss_q[3];

    emit_mid  = mul_run && comb_y;
    emit_last = (state_q == ST_LAST) && out_free;

    mac_ctl.mul_en = issue;
    mac_ctl.acc_en = mul_run && pv_q;
    case (pop_q)
      OP_L_C, OP_L_S: mac_ctl.mode = MAC_LOAD;
      OP_H_S:         mac_ctl.mode = MAC_SUB;
      OP_H_C:         mac_ctl.mode = MAC_ADD;
      default:        mac_ctl.mode = MAC_BASE;
    endcase
    mac_base = comb_y ? prev_y_q : prev_x_q;

    // operands; lengths are non-negative, d = L - r may be negative
    len_l = $signed({1'b0, side_q});
    len_r = $signed({1'b0, cut_q});
    len_h = $signed({1'b0, peak_q});
    len_d = len_l - len_r;
    case (iss_q[2:0])
      OP_R_C, OP_R_S:  op_a = len_r;
      OP_L_C, OP_L_S:  op_a = len_l;
      OP_H_S, OP_H_C:  op_a = len_h;
      default:         op_a = len_d;
    endcase
    case (iss_q[2:0])
      OP_R_C, OP_L_C, OP_H_C, OP_D_C: op_b = cos_w;
      default:                        op_b = sin_w;
    endcase

    // headings: base 1 turns left, apex turns right, base 2 keeps course
    alfa = ANGLE_BITS'(turn_q);
    case (pop_q)
      OP_R_S:  emit_hd = prev_hd_q + alfa;
      OP_H_C:  emit_hd = prev_hd_q - alfa;
      default: emit_hd = prev_hd_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------------
  ccss_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (prev_hd_q),
    .done_o  (cordic_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  ccss_mac u_mac (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .mul_a_i (op_a),
    .mul_b_i (op_b),
    .base_i  (mac_base),
    .coord_o (coord)
  );

  // ---------------------------------------------------------------------------
  // sequencer, config and held vertex
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      pv_q        <= 1'b0;
      pop_q       <= '0;
      side_q      <= 31'd196608;
      cut_q       <= 31'd58668;
      peak_q      <= 31'd43254;
      turn_q      <= 16'd8647;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_hd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SIDE_LENGTH: side_q <= cfg_wdata_i;
          REG_CUT_LENGTH:  cut_q  <= cfg_wdata_i;
          REG_PEAK_HEIGHT: peak_q <= cfg_wdata_i;
          REG_TURN_ANGLE:  turn_q <= cfg_wdata_i[15:0];
          default:         turn_q <= turn_q;
        endcase
      end

      if (emit_mid || emit_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= in_data_i.starts_curve ? ST_LAST : ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cordic_done) begin
            state_q <= ST_MUL;
            iss_q   <= '0;
            pv_q    <= 1'b0;
          end
        end
        ST_MUL: begin
          if (mul_run) begin
            if (issue) begin
              iss_q <= iss_q + 4'd1;
            end
            pv_q  <= issue;
            pop_q <= iss_q[2:0];
            if (pv_q && pop_q == OP_D_S) begin
              state_q <= ST_LAST;
            end
          end
        end
        ST_LAST: begin
          if (out_free) begin
            state_q   <= ST_IDLE;
            prev_x_q  <= cur_x_q;
            prev_y_q  <= cur_y_q;
            prev_hd_q <= cur_hd_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_x_q  <= in_data_i.point_x;
      cur_y_q  <= in_data_i.point_y;
      cur_hd_q <= ANGLE_BITS'(in_data_i.point_heading);
    end
    if (mul_run && comb_x) begin
      ox_q <= coord;
    end
    if (emit_mid) begin
      out_data_q.out_x       <= ox_q;
      out_data_q.out_y       <= coord;
      out_data_q.out_heading <= 16'(emit_hd);
      out_data_q.last_of_run <= 1'b0;
    end else if (emit_last) begin
      out_data_q.out_x       <= cur_x_q;
      out_data_q.out_y       <= cur_y_q;
      out_data_q.out_heading <= 16'(cur_hd_q);
      out_data_q.last_of_run <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a beat");

  a_pop_tracks_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> pop_q == 3'(iss_q - 4'd1))
    else $error("product in flight does not match issue counter");

  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == ST_CORDIC)
    else $error("CORDIC finished outside its wait state");

  a_last_beat_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAST && out_free |=> out_valid_o && out_data_o.last_of_run)
    else $error("final beat not presented");

  a_stall_holds_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL && stall |=> $stable(iss_q) && $stable(pop_q) && pv_q)
    else $error("multiply schedule moved while output stalled");

endmodule

### rtl/core/ccss_cordic.sv
// ----------------------------------------------------------------------------
// ccss_cordic: iterative CORDIC sine/cosine
// One rotation step per cycle, then a last step undoes the half-turn fold.
// ----------------------------------------------------------------------------
module ccss_cordic import ccss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  angle_t             angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic                     busy_q, fix_q, done_q, flip_q;
  logic [STEP_W-1:0]        step_q;
  logic signed [31:0]       x_q, y_q;
  logic signed [33:0]       z_q;

  logic [31:0]              u, uf;
  logic                     flip_d;
  logic                     last_step;
  logic signed [31:0]       x_sh, y_sh;
  logic signed [33:0]       at;

  always_comb begin
    u         = {angle_i, {(32-ANGLE_BITS){1'b0}}};
    flip_d    = u[31] ^ u[30];              // heading in [90,270)
    uf        = {u[31] ^ flip_d, u[30:0]};
    x_sh      = x_q >>> step_q;
    y_sh      = y_q >>> step_q;
    at        = $signed({2'b00, atan_lut(5'(step_q))});
    last_step = busy_q && !start_i && (step_q == STEP_W'(CORDIC_N - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (last_step) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      z_q    <= 34'($signed(uf));
      flip_q <= flip_d;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + at;
      end
    end else if (fix_q && flip_q) begin
      x_q <= -x_q;
      y_q <= -y_q;
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

endmodule

### rtl/core/ccss_mac.sv
// ----------------------------------------------------------------------------
// ccss_mac: shared 32x32 multiplier with accumulator and rounding
// Product is registered; the next cycle loads it into the accumulator or
// folds it into a rounded offset added to the segment start coordinate.
// ----------------------------------------------------------------------------
module ccss_mac import ccss_pkg::*; (
  input  logic               clk_i,
  input  mac_ctl_t           ctl_i,
  input  logic signed [31:0] mul_a_i,
  input  logic signed [31:0] mul_b_i,
  input  logic        [31:0] base_i,
  output logic        [31:0] coord_o
);

  localparam logic signed [65:0] RND_BASE = 66'sd1 <<< (TRIG_FRAC - 1);
  localparam logic signed [65:0] RND_APEX = 66'sd1 <<< TRIG_FRAC;

  logic signed [63:0] prod_q;
  logic signed [64:0] acc_q;
  logic signed [65:0] lhs, rhs, rnd, sum;
  logic signed [31:0] off;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= mul_a_i * mul_b_i;
    end
    if (ctl_i.acc_en && ctl_i.mode == MAC_LOAD) begin
      acc_q <= 65'(prod_q);
    end
  end

  always_comb begin
    lhs = '0;
    rhs = '0;
    rnd = '0;
    case (ctl_i.mode)
      MAC_BASE: begin
        rhs = 66'(prod_q);
        rnd = RND_BASE;
      end
      MAC_SUB: begin
        lhs = 66'(acc_q);
        rhs = -(66'(prod_q) <<< 1);
        rnd = RND_APEX;
      end
      MAC_ADD: begin
        lhs = 66'(acc_q);
        rhs = 66'(prod_q) <<< 1;
        rnd = RND_APEX;
      end
      default: begin
        rhs = '0;
      end
    endcase
    sum = lhs + rhs + rnd;
    if (ctl_i.mode == MAC_BASE) begin
      off = 32'(sum >>> TRIG_FRAC);
    end else begin
      off = 32'(sum >>> (TRIG_FRAC + 1));
    end
    coord_o = base_i + $unsigned(off);
  end

endmodule

### bench/ccss_tb_pkg.sv
// ----------------------------------------------------------------------------
// ccss_tb_pkg: scoreboard for the Cesaro segment subdivider bench
// Keeps its own copy of the level registers and the held vertex, expands
// every accepted vertex into the beats the block must emit, and compares
// each output beat against the oldest one still pending.
// ----------------------------------------------------------------------------
package ccss_tb_pkg;
  import ccss_pkg::*;

  typedef enum logic [1:0] {
    REG_SIDE_LENGTH,
    REG_CUT_LENGTH,
    REG_PEAK_HEIGHT,
    REG_TURN_ANGLE
  } cfg_reg_e;

  localparam int     ROT_STEPS   = 16;
  localparam longint ROT_GAIN    = 64'sd652032874;  // 0.6072529350 in Q30

  // atan(2^-i), 2^32 units per turn
  localparam longint ATAN_TURNS [24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  class segment_scoreboard;
    logic        [30:0] seg_len;
    logic        [30:0] base_dist;
    logic        [30:0] apex_rise;
    angle_t             turn;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    angle_t             last_heading;
    ccss_out_t          pending_points [$];
    int unsigned        failures;

    function new();
      seg_len      = 31'd196608;
      base_dist    = 31'd58668;
      apex_rise    = 31'd43254;
      turn         = 16'd8647;
      last_x       = '0;
      last_y       = '0;
      last_heading = '0;
      failures     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [30:0] val);
      case (idx)
        REG_SIDE_LENGTH: seg_len   = val;
        REG_CUT_LENGTH:  base_dist = val;
        REG_PEAK_HEIGHT: apex_rise = val;
        REG_TURN_ANGLE:  turn      = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending_points.size();
    endfunction

    // Q30 cos/sin; headings in [90,270) rotate by a half turn, then negate
    function void heading_cos_sin(angle_t a, output longint c, output longint s);
      logic [31:0] u;
      logic        flip;
      longint      x, y, z, nx;
      u    = 32'(a) << (32 - ANGLE_BITS);
      flip = u[31] ^ u[30];
      if (flip) u[31] = ~u[31];
      z = longint'($signed(u));
      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ATAN_TURNS[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ATAN_TURNS[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = x;
      s = y;
    endfunction

    function logic [31:0] shift_round(longint p, int unsigned sh);
      longint q;
      q = (p + (64'sd1 <<< (sh - 1))) >>> sh;
      return q[31:0];
    endfunction

    function void push_point(logic [31:0] x, logic [31:0] y, angle_t hd, logic last);
      ccss_out_t pt;
      pt.out_x       = x;
      pt.out_y       = y;
      pt.out_heading = hd;
      pt.last_of_run = last;
      pending_points.insert(pending_points.size(), pt);
    endfunction

    function void note_vertex(ccss_in_t v);
      longint c, s, len, cut, hgt, rest;
      if (!v.starts_curve) begin
        heading_cos_sin(last_heading, c, s);
        len  = seg_len;
        cut  = base_dist;
        hgt  = apex_rise;
        rest = len - cut;
        push_point(last_x + shift_round(cut * c, 30), last_y + shift_round(cut * s, 30),
                   last_heading + turn, 1'b0);
        push_point(last_x + shift_round(len * c - 2 * hgt * s, 31),
                   last_y + shift_round(len * s + 2 * hgt * c, 31),
                   last_heading - turn, 1'b0);
        push_point(last_x + shift_round(rest * c, 30), last_y + shift_round(rest * s, 30),
                   last_heading, 1'b0);
      end
      push_point(v.point_x, v.point_y, v.point_heading, 1'b1);
      last_x       = v.point_x;
      last_y       = v.point_y;
      last_heading = v.point_heading;
    endfunction

    function void check_point(ccss_out_t got);
      ccss_out_t want;
      logic      bad;
      if (pending_points.size() == 0) begin
        $error("unexpected output beat: %p", got);
        failures++;
        return;
      end
      want = pending_points.pop_front();
      bad  = 1'b0;
      if (got.out_x !== want.out_x) begin
        $error("out_x: expected %h, got %h", want.out_x, got.out_x);
        bad = 1'b1;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y: expected %h, got %h", want.out_y, got.out_y);
        bad = 1'b1;
      end
      if (got.out_heading !== want.out_heading) begin
        $error("out_heading: expected %h, got %h", want.out_heading,
               got.out_heading);
        bad = 1'b1;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, got %b", want.last_of_run,
               got.last_of_run);
        bad = 1'b1;
      end
      if (bad) failures++;
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for cesaro_curve_segment_subdivider
// Streams curve levels (start vertex plus a run of vertices) through the
// block under several level settings, with random gaps on both handshakes,
// one long output hold-off and drain pauses, and checks every output beat
// against a scoreboard that expands each accepted vertex on its own.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccss_pkg::*;
  import ccss_tb_pkg::*;

  // Slowest legal vertex: 4 beats, each behind a random output stall, plus
  // a random input gap. RUN_LIMIT is set well above what the ~310 items
  // and the hold-off need.
  localparam int unsigned RUN_LIMIT = 400_000;
  localparam int unsigned TAIL      = 40;    // wait after the last beat before the next level
  localparam int unsigned HOLD_OFF  = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  ccss_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  ccss_out_t   out_data_o;

  segment_scoreboard sb;

  // per-side idling switches and the one-shot receiver hold-off request
  logic        tx_idle     = 1'b1;
  logic        rx_idle     = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  cesaro_curve_segment_subdivider i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned draw_gap(logic on);
    return on ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic ccss_in_t make_vertex(logic [31:0] x, logic [31:0] y,
                                           logic [15:0] hd, logic start);
    ccss_in_t v;
    v.point_x       = x;
    v.point_y       = y;
    v.point_heading = hd;
    v.starts_curve  = start;
    return v;
  endfunction

  function automatic ccss_in_t rand_vertex(logic start);
    return make_vertex($urandom, $urandom, 16'($urandom_range(0, 65535)), start);
  endfunction

  // Register write: one beat on the config port, only while the block is idle.
  task automatic write_reg(cfg_reg_e idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_level(logic [30:0] len, logic [30:0] cut, logic [30:0] hgt,
                            logic [15:0] turn);
    write_reg(REG_SIDE_LENGTH, len);
    write_reg(REG_CUT_LENGTH, cut);
    write_reg(REG_PEAK_HEIGHT, hgt);
    write_reg(REG_TURN_ANGLE, 31'(turn));
  endtask

  // Offer one vertex after a random gap; valid holds until the beat is taken.
  // Valid is only touched at falling edges, once per edge.
  task automatic send_vertex(ccss_in_t v);
    int unsigned gap;
    gap = draw_gap(tx_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_vertex(v);
  endtask

  // Drop valid, then wait until every pending beat has come out and the
  // block has had time to go idle.
  task automatic drain(int unsigned tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Curve levels: mostly a start vertex followed by a run of vertices, now
  // and then a level with its start missing or a stray start mid-run.
  task automatic run_curves(int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) != 0) begin
        send_vertex(rand_vertex(1'b1));
        sent++;
      end
      run_len = $urandom_range(1, 7);
      repeat (run_len) begin
        send_vertex(rand_vertex($urandom_range(0, 15) == 0));
        sent++;
      end
    end
  endtask

  // Receiver: random stall before each beat, or the long hold-off when asked.
  // The hold-off keeps ready low while the sender keeps offering, so the
  // output register fills and the input side backs up.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = draw_gap(rx_idle);
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Output monitor: pre-edge values at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_point(out_data_o);
  end

  // Watchdog
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset-value level. First vertex has no start before it, so the
    // segment begins at the cleared held vertex. Headings then walk over
    // the quadrant edges, where the half-turn fold switches on and off, and
    // coordinates at the extremes make the next offsets wrap.
    send_vertex(make_vertex(32'h0001_0000, 32'h0002_0000, 16'h4000, 1'b0));
    send_vertex(make_vertex(32'h0000_0000, 32'h0000_0000, 16'h3FFF, 1'b1));
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 1'b0));
    send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 1'b0));
    send_vertex(make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 1'b0));
    send_vertex(make_vertex(32'h0000_0000, 32'h0000_0000, 16'hBFFF, 1'b0));
    send_vertex(make_vertex(32'h0003_0000, 32'h0000_0000, 16'hC000, 1'b0));
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b0));
    send_vertex(make_vertex(32'h0000_0000, 32'h8000_0000, 16'h0000, 1'b0));
    // back-to-back starts
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1));
    send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b1));
    send_vertex(make_vertex(32'h0000_0000, 32'h0000_0000, 16'h2AAA, 1'b0));
    send_vertex(make_vertex(32'h1234_5678, 32'hFFFF_EDCC, 16'h5555, 1'b0));
    run_curves(40);
    drain(TAIL);

    // All lengths and the turn at zero; no idling on either side.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    load_level('0, '0, '0, '0);
    run_curves(40);
    drain(TAIL);

    // Everything at its maximum, with the long output hold-off.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_level(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    hold_cycles = HOLD_OFF;
    run_curves(50);
    drain(TAIL);

    // Cut longer than the side: second base point lies behind the start.
    // The sender also pauses mid-level until the output has caught up.
    load_level(31'($urandom_range(0, 32'h0004_0000)), 31'h7FFF_FFFF, 31'($urandom),
               16'($urandom));
    run_curves(25);
    drain(0);
    run_curves(25);
    drain(TAIL);

    // Random level, sender idles, receiver always ready.
    rx_idle = 1'b0;
    load_level(31'($urandom), 31'($urandom), 31'($urandom), 16'($urandom));
    run_curves(60);
    drain(TAIL);

    // Random level, sender back to back, receiver stalls.
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    load_level(31'($urandom), 31'($urandom), 31'($urandom), 16'($urandom));
    run_curves(60);
    drain(TAIL);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### cesaro_curve_segment_subdivider.f
rtl/core/ccss_pkg.sv
rtl/core/ccss_cordic.sv
rtl/core/ccss_mac.sv
rtl/core/cesaro_curve_segment_subdivider.sv
bench/ccss_tb_pkg.sv
bench/tb_top.sv
